### hw/rtl/state_space_step_macros.svh
// ----------------------------------------------------------------------------
// state_space_step_macros.svh
// Assertion shorthands shared by the state-space step block.
// ----------------------------------------------------------------------------
`ifndef STATE_SPACE_STEP_MACROS_SVH
`define STATE_SPACE_STEP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SST_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Types, register map and fixed-point helpers of the state-space step block.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned VAL_W  = 24;
  localparam int unsigned CNT_W  = 16;

  // Register bit widths, used to drop coefficients that fall outside.
  localparam int unsigned A_BITS    = 64;
  localparam int unsigned B_BITS    = 32;
  localparam int unsigned C_BITS    = 64;
  localparam int unsigned D_BITS    = 32;
  localparam int unsigned INIT_BITS = 48;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [29:0]       prod_t;
  typedef logic signed [33:0]       acc_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [2:0]               reg_idx_t;

  localparam reg_idx_t REG_A    = 3'd0;
  localparam reg_idx_t REG_B    = 3'd1;
  localparam reg_idx_t REG_C    = 3'd2;
  localparam reg_idx_t REG_D    = 3'd3;
  localparam reg_idx_t REG_INIT = 3'd4;

  localparam cnt_t COUNT_MAX = 16'hFFFF;
  localparam acc_t ACC_MAX   = 34'sd8388607;
  localparam acc_t ACC_MIN   = -34'sd8388608;
  localparam val_t VAL_MAX   = 24'sh7FFFFF;
  localparam val_t VAL_MIN   = 24'sh800000;

  // Q4.11 coefficient times a value with 12 fraction bits, rounded half up
  // (floor after adding one half) back to 12 fraction bits.
  function automatic prod_t mul_round(coef_t c, val_t v);
    logic signed [40:0] p;
    p = $signed({{25{c[15]}}, c}) * $signed({{17{v[23]}}, v});
    p = p + 41'sd1024;
    return p[40:11];
  endfunction

  function automatic val_t sat_val(acc_t a);
    if (a > ACC_MAX) begin
      return VAL_MAX;
    end else if (a < ACC_MIN) begin
      return VAL_MIN;
    end
    return a[23:0];
  endfunction

  function automatic logic sat_hit(acc_t a);
    return (a > ACC_MAX) || (a < ACC_MIN);
  endfunction

endpackage

### hw/rtl/sst_in_if.sv
// ----------------------------------------------------------------------------
// sst_in_if
// Input sample channel: restart flag and drive sample.
// ----------------------------------------------------------------------------
interface sst_in_if;
  logic          valid;
  logic          ready;
  logic          restart;
  sst_pkg::val_t drive_input;

  modport source (output valid, restart, drive_input, input ready);
  modport sink   (input valid, restart, drive_input, output ready);
endinterface

### hw/rtl/sst_out_if.sv
// ----------------------------------------------------------------------------
// sst_out_if
// Result channel: outputs, state used, sample number and overflow flag.
// ----------------------------------------------------------------------------
interface sst_out_if;
  logic          valid;
  logic          ready;
  sst_pkg::val_t output_first;
  sst_pkg::val_t output_second;
  sst_pkg::val_t state_first;
  sst_pkg::val_t state_second;
  sst_pkg::cnt_t sample_index;
  logic          overflow;

  modport source (output valid, output_first, output_second, state_first, state_second,
                  sample_index, overflow, input ready);
  modport sink   (input valid, output_first, output_second, state_first, state_second,
                  sample_index, overflow, output ready);
endinterface

### hw/rtl/sst_step_math.sv
// ----------------------------------------------------------------------------
// sst_step_math
// One step of the state-space update: y = C*x + D*u and x' = A*x + B*u,
// with rounded products and saturated sums.
// ----------------------------------------------------------------------------
module sst_step_math #(
  parameter int unsigned STATE_COUNT  = 2,
  parameter int unsigned INPUT_COUNT  = 1,
  parameter int unsigned OUTPUT_COUNT = 2
) (
  input  sst_pkg::coef_t a_coef_i [STATE_COUNT*STATE_COUNT],
  input  sst_pkg::coef_t b_coef_i [STATE_COUNT*INPUT_COUNT],
  input  sst_pkg::coef_t c_coef_i [OUTPUT_COUNT*STATE_COUNT],
  input  sst_pkg::coef_t d_coef_i [OUTPUT_COUNT*INPUT_COUNT],
  input  sst_pkg::val_t  x_i      [STATE_COUNT],
  input  sst_pkg::val_t  u_i,
  output sst_pkg::val_t  y_o      [OUTPUT_COUNT],
  output sst_pkg::val_t  xn_o     [STATE_COUNT],
  output logic           ovf_o
);
  import sst_pkg::*;

  val_t u_vec [INPUT_COUNT];
  acc_t y_acc [OUTPUT_COUNT];
  acc_t x_acc [STATE_COUNT];

  // Only the first drive input is fed; any further ones are zero.
  always_comb begin
    for (int j = 0; j < INPUT_COUNT; j++) begin
      u_vec[j] = (j == 0) ? u_i : '0;
    end
  end

  always_comb begin
    ovf_o = 1'b0;
    for (int i = 0; i < OUTPUT_COUNT; i++) begin
      y_acc[i] = '0;
      for (int j = 0; j < STATE_COUNT; j++) begin
        y_acc[i] = y_acc[i] + acc_t'(mul_round(c_coef_i[i*STATE_COUNT+j], x_i[j]));
      end
      for (int j = 0; j < INPUT_COUNT; j++) begin
        y_acc[i] = y_acc[i] + acc_t'(mul_round(d_coef_i[i*INPUT_COUNT+j], u_vec[j]));
      end
      y_o[i] = sat_val(y_acc[i]);
      ovf_o  = ovf_o | sat_hit(y_acc[i]);
    end
    for (int i = 0; i < STATE_COUNT; i++) begin
      x_acc[i] = '0;
      for (int j = 0; j < STATE_COUNT; j++) begin
        x_acc[i] = x_acc[i] + acc_t'(mul_round(a_coef_i[i*STATE_COUNT+j], x_i[j]));
      end
      for (int j = 0; j < INPUT_COUNT; j++) begin
        x_acc[i] = x_acc[i] + acc_t'(mul_round(b_coef_i[i*INPUT_COUNT+j], u_vec[j]));
      end
      xn_o[i] = sat_val(x_acc[i]);
      ovf_o   = ovf_o | sat_hit(x_acc[i]);
    end
  end

endmodule

### hw/rtl/state_space_step.sv
// ----------------------------------------------------------------------------
// state_space_step
// Discrete-time linear state-space system in fixed point. Each input sample
// gives one result with y = C*x + D*u and the state used, then x advances.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake        Contents
//   in_i      sink       valid / ready    restart, drive_input
//   out_o     source     valid / ready    outputs, states, sample_index, overflow
//   APB       slave      psel / penable   coefficient and initial-state registers
//
// An accepted sample is held in the input register, and the full multiply,
// round and saturate pass runs combinationally from there into the result
// register. One sample is taken every cycle while the result is not stalled.
// The state register feeds back into that single pass, which sets the rate.
// Reset clears the configuration registers, the state and the sample count;
// the first sample after reset loads the initial state. A stalled result holds
// in the result register while one more sample waits in the input register.
//
`include "state_space_step_macros.svh"

module state_space_step #(
  parameter int unsigned STATE_COUNT  = 2,
  parameter int unsigned INPUT_COUNT  = 1,
  parameter int unsigned OUTPUT_COUNT = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sst_in_if.sink                      in_i,
  sst_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sst_pkg::ADDR_W-1:0]  paddr,
  input  logic [sst_pkg::DATA_W-1:0]  pwdata,
  output logic [sst_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import sst_pkg::*;

  // Configuration registers.
  logic [A_BITS-1:0]    a_q;
  logic [B_BITS-1:0]    b_q;
  logic [C_BITS-1:0]    c_q;
  logic [D_BITS-1:0]    d_q;
  logic [INIT_BITS-1:0] init_q;
  logic                 cfg_we;
  reg_idx_t             cfg_idx;

  // Input stage.
  logic s1_valid_q, s1_valid_d;
  logic s1_restart_q;
  val_t s1_u_q;
  logic in_acc;
  logic s1_adv;

  // Running state.
  val_t x_q [STATE_COUNT];
  logic started_q;
  cnt_t cnt_q, cnt_d;
  logic load_init;

  // Result register.
  logic out_valid_q, out_valid_d;
  val_t out_y0_q, out_y1_q, out_x0_q, out_x1_q;
  cnt_t out_cnt_q;
  logic out_ovf_q;

  // Datapath wires.
  coef_t a_coef [STATE_COUNT*STATE_COUNT];
  coef_t b_coef [STATE_COUNT*INPUT_COUNT];
  coef_t c_coef [OUTPUT_COUNT*STATE_COUNT];
  coef_t d_coef [OUTPUT_COUNT*INPUT_COUNT];
  val_t  x_init [STATE_COUNT];
  val_t  x_used [STATE_COUNT];
  val_t  y      [OUTPUT_COUNT];
  val_t  xn     [STATE_COUNT];
  logic  ovf;
  val_t  y_second, x_second;

  // --------------------------------------------------------------------------
  // APB register file. Registers sit on 8-byte boundaries; indexes beyond the
  // list are ignored on write and read back as zero.
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[5:3];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      c_q    <= '0;
      d_q    <= '0;
      init_q <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_A:    a_q    <= pwdata[A_BITS-1:0];
        REG_B:    b_q    <= pwdata[B_BITS-1:0];
        REG_C:    c_q    <= pwdata[C_BITS-1:0];
        REG_D:    d_q    <= pwdata[D_BITS-1:0];
        REG_INIT: init_q <= pwdata[INIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_A:    prdata = DATA_W'(a_q);
      REG_B:    prdata = DATA_W'(b_q);
      REG_C:    prdata = DATA_W'(c_q);
      REG_D:    prdata = DATA_W'(d_q);
      REG_INIT: prdata = DATA_W'(init_q);
      default:  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Coefficient unpacking. Element k of a matrix sits at bits k*16 of its
  // register; an element that would lie past the register's top reads as zero.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < STATE_COUNT*STATE_COUNT; k++) begin : g_a
    if ((k + 1) * COEF_W <= A_BITS) begin : g_in
      assign a_coef[k] = a_q[k*COEF_W +: COEF_W];
    end else begin : g_zero
      assign a_coef[k] = '0;
    end
  end
  for (genvar k = 0; k < STATE_COUNT*INPUT_COUNT; k++) begin : g_b
    if ((k + 1) * COEF_W <= B_BITS) begin : g_in
      assign b_coef[k] = b_q[k*COEF_W +: COEF_W];
    end else begin : g_zero
      assign b_coef[k] = '0;
    end
  end
  for (genvar k = 0; k < OUTPUT_COUNT*STATE_COUNT; k++) begin : g_c
    if ((k + 1) * COEF_W <= C_BITS) begin : g_in
      assign c_coef[k] = c_q[k*COEF_W +: COEF_W];
    end else begin : g_zero
      assign c_coef[k] = '0;
    end
  end
  for (genvar k = 0; k < OUTPUT_COUNT*INPUT_COUNT; k++) begin : g_d
    if ((k + 1) * COEF_W <= D_BITS) begin : g_in
      assign d_coef[k] = d_q[k*COEF_W +: COEF_W];
    end else begin : g_zero
      assign d_coef[k] = '0;
    end
  end
  // States past the initial-state register start from zero.
  for (genvar k = 0; k < STATE_COUNT; k++) begin : g_x0
    if ((k + 1) * VAL_W <= INIT_BITS) begin : g_in
      assign x_init[k] = init_q[k*VAL_W +: VAL_W];
    end else begin : g_zero
      assign x_init[k] = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. The input stage moves on whenever the result register is
  // empty or being emptied, so a new sample enters every cycle in steady flow.
  // --------------------------------------------------------------------------
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_restart_q <= in_i.restart;
      s1_u_q       <= in_i.drive_input;
    end
  end

  // --------------------------------------------------------------------------
  // The first sample after reset, or one with restart set, starts from the
  // initial state and restarts the sample count at one.
  // --------------------------------------------------------------------------
  assign load_init = s1_restart_q || !started_q;

  always_comb begin
    for (int i = 0; i < STATE_COUNT; i++) begin
      x_used[i] = load_init ? x_init[i] : x_q[i];
    end
    if (load_init) begin
      cnt_d = cnt_t'(1);
    end else if (cnt_q == COUNT_MAX) begin
      cnt_d = cnt_q;
    end else begin
      cnt_d = cnt_q + cnt_t'(1);
    end
  end

  sst_step_math #(
    .STATE_COUNT  (STATE_COUNT),
    .INPUT_COUNT  (INPUT_COUNT),
    .OUTPUT_COUNT (OUTPUT_COUNT)
  ) u_math (
    .a_coef_i (a_coef),
    .b_coef_i (b_coef),
    .c_coef_i (c_coef),
    .d_coef_i (d_coef),
    .x_i      (x_used),
    .u_i      (s1_u_q),
    .y_o      (y),
    .xn_o     (xn),
    .ovf_o    (ovf)
  );

  // Result fields with no matching element read as zero.
  if (OUTPUT_COUNT > 1) begin : g_y1
    assign y_second = y[1];
  end else begin : g_y1_zero
    assign y_second = '0;
  end
  if (STATE_COUNT > 1) begin : g_x1
    assign x_second = x_used[1];
  end else begin : g_x1_zero
    assign x_second = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      cnt_q     <= '0;
      for (int i = 0; i < STATE_COUNT; i++) begin
        x_q[i] <= '0;
      end
    end else if (s1_adv) begin
      started_q <= 1'b1;
      cnt_q     <= cnt_d;
      for (int i = 0; i < STATE_COUNT; i++) begin
        x_q[i] <= xn[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_y0_q  <= y[0];
      out_y1_q  <= y_second;
      out_x0_q  <= x_used[0];
      out_x1_q  <= x_second;
      out_cnt_q <= cnt_d;
      out_ovf_q <= ovf;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.output_first  = out_y0_q;
  assign out_o.output_second = out_y1_q;
  assign out_o.state_first   = out_x0_q;
  assign out_o.state_second  = out_x1_q;
  assign out_o.sample_index  = out_cnt_q;
  assign out_o.overflow      = out_ovf_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `SST_ASSERT_NEXT(a_started_sticky, clk_i, rst_ni, started_q, started_q, "started flag dropped")
  `SST_ASSERT_SAME(a_index_nonzero, clk_i, rst_ni, out_valid_q, out_cnt_q != '0, "sample index is zero")
  `SST_ASSERT_NEXT(a_restart_index, clk_i, rst_ni, s1_adv && load_init, out_valid_q && (out_cnt_q == cnt_t'(1)), "restart did not give index one")
  `SST_ASSERT_SAME(a_no_drop, clk_i, rst_ni, s1_valid_q && out_valid_q && !out_o.ready, !in_i.ready, "input taken with both stages full")

endmodule
